// ===== sv/alc_pkg.sv =====
// shared types, constants and helper functions for the lux calculator
package alc_pkg;

    localparam int RAW_W    = 16;
    localparam int SCALE_W  = 19;
    localparam int CH_W     = 25;
    localparam int QUO_W    = 12;
    localparam int COEF_W   = 10;
    localparam int LUX_W    = 21;
    localparam int PROD_W   = CH_W + COEF_W;
    localparam int SCALE_CH = 10;
    localparam int SCALE_LUX = 14;
    localparam int SEGMENTS = 7;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 3;

    localparam logic [1:0] CFG_GAIN  = 2'd0;
    localparam logic [1:0] CFG_INTEG = 2'd1;
    localparam logic [1:0] CFG_PKG   = 2'd2;

    localparam logic [1:0] INT_13MS  = 2'd0;
    localparam logic [1:0] INT_101MS = 2'd1;

    localparam logic [SCALE_W-1:0] CH_SCALE_T0 = 19'h07517;
    localparam logic [SCALE_W-1:0] CH_SCALE_T1 = 19'h00fe7;
    localparam logic [SCALE_W-1:0] CH_SCALE_NONE = 19'h00400;
    localparam logic [RAW_W-1:0] INVALID_LIMIT = 16'd4900;

    localparam logic [COEF_W-1:0] KNEE_TAB [2][SEGMENTS] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
    };
    localparam logic [COEF_W-1:0] OFFSET_TAB [2][SEGMENTS] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
    };
    localparam logic [COEF_W-1:0] SLOPE_TAB [2][SEGMENTS] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}
    };

    typedef struct packed {
        logic       gain_hi;
        logic [1:0] integ;
        logic       pkg;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] ch0s;
        logic [CH_W-1:0] ch1s;
        logic            pkg;
        logic            bad;
    } scaled_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch0s;
        logic [CH_W-1:0]  ch1s;
        logic             pkg;
        logic             bad;
        logic             zro;
        logic             sat;
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] tail;
    } div_t;

    typedef struct packed {
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } coef_t;

    // DIV_STEPS restoring division steps, one quotient bit each
    function automatic div_t div_steps(input div_t d);
        div_t          r;
        logic [CH_W:0] r2;
        logic [CH_W:0] dd;
        r  = d;
        dd = {1'b0, d.ch0s};
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r2 = {r.rem, r.tail[QUO_W-1]};
            r.quo = {r.quo[QUO_W-2:0], 1'b0};
            if (r2 >= dd)
            begin
                r2 = r2 - dd;
                r.quo[0] = 1'b1;
            end
            r.rem  = r2[CH_W-1:0];
            r.tail = {r.tail[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // first segment whose knee is not below the ratio
    function automatic coef_t coef_lookup(input logic pkg, input logic [QUO_W-1:0] ratio);
        coef_t c;
        c.b = '0;
        c.m = '0;
        for (int i = SEGMENTS - 1; i >= 0; i--)
        begin
            if (ratio <= {2'b00, KNEE_TAB[pkg][i]})
            begin
                c.b = OFFSET_TAB[pkg][i];
                c.m = SLOPE_TAB[pkg][i];
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/ambient_light_lux_calc.sv =====
// top level of the two-channel lux calculator
//
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  s_tdata: broadband_count, infrared_count
// m_*      out        m_tvalid/m_tready  m_tdata: lux; m_tuser: invalid
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// the pipe is one scaling stage with the channel multipliers, five divider
// stages (setup plus three ratio bits per stage), then lookup, product and
// rounding stages. one item can enter every cycle while m_tready does not stall it.
// reset clears the valid bits and the configuration registers to zero.
// each stage holds its item while the next one is full and held, so a stall on m_tready
// backs up stage by stage and bubbles in the pipe are still filled.
module ambient_light_lux_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] broadband_count, [31:16] infrared_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] lux, [23:21] zero
    output logic [0:0]  m_tuser,    // [0] invalid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    import alc_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        sc_valid, sc_ready;
    scaled_t     sc_data;
    logic        dv_valid, dv_ready;
    div_t        dv_data;
    logic [20:0] lux;
    logic        invalid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN:  cfg_next.gain_hi = cfg_data[0];
                CFG_INTEG: cfg_next.integ   = cfg_data;
                CFG_PKG:   cfg_next.pkg     = cfg_data[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    alc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw0      (s_tdata[15:0]),
        .raw1      (s_tdata[31:16]),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_data  (sc_data)
    );

    alc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_data   (sc_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    alc_lux u_lux (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_data   (dv_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .lux       (lux),
        .invalid   (invalid)
    );

    assign m_tdata = {3'b000, lux};
    assign m_tuser = invalid;

endmodule

// ===== sv/alc_scale.sv =====
// channel scaling stage and invalid flag
module alc_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alc_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           raw0,
    input  logic [15:0]           raw1,
    output logic                  out_valid,
    input  logic                  out_ready,
    output alc_pkg::scaled_t      out_data
);
    import alc_pkg::*;

    logic                    v_reg;
    logic                    v_next;
    scaled_t                 d_reg;
    scaled_t                 d_next;
    logic [SCALE_W-1:0]      scale;
    logic [RAW_W+SCALE_W-1:0] p0;
    logic [RAW_W+SCALE_W-1:0] p1;
    logic                    adv;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        case (cfg.integ)
            INT_13MS:  scale = CH_SCALE_T0;
            INT_101MS: scale = CH_SCALE_T1;
            default:   scale = CH_SCALE_NONE;
        endcase
        if (!cfg.gain_hi)
            scale = {scale[SCALE_W-5:0], 4'b0000};
        p0 = {{SCALE_W{1'b0}}, raw0} * {{RAW_W{1'b0}}, scale};
        p1 = {{SCALE_W{1'b0}}, raw1} * {{RAW_W{1'b0}}, scale};
        d_next.ch0s = p0[RAW_W+SCALE_W-1:SCALE_CH];
        d_next.ch1s = p1[RAW_W+SCALE_W-1:SCALE_CH];
        d_next.pkg  = cfg.pkg;
        // quotient below two is the same as raw0 < 2*raw1
        d_next.bad  = (raw1 != '0) && ({1'b0, raw0} < {raw1, 1'b0})
                      && (raw0 > INVALID_LIMIT);
        v_next = adv ? in_valid : v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// ===== sv/alc_div.sv =====
// pipelined restoring divider for the ir/broadband ratio
module alc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  alc_pkg::scaled_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output alc_pkg::div_t     out_data
);
    import alc_pkg::*;

    localparam int NST = DIV_STAGES + 1;

    logic       v_reg [NST];
    div_t       d_reg [NST];
    logic       adv   [NST];
    div_t       setup;

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    // quotient fits 12 bits unless ch1s >= 4*ch0s, which saturates the ratio
    always_comb
    begin
        setup.ch0s = in_data.ch0s;
        setup.ch1s = in_data.ch1s;
        setup.pkg  = in_data.pkg;
        setup.bad  = in_data.bad;
        setup.zro  = (in_data.ch0s == '0);
        setup.sat  = ({2'b00, in_data.ch1s} >= {in_data.ch0s, 2'b00});
        setup.rem  = {2'b00, in_data.ch1s[CH_W-1:2]};
        setup.quo  = '0;
        setup.tail = {in_data.ch1s[1:0], {(QUO_W-2){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
            d_reg[0] <= setup;
        for (int k = 1; k < NST; k++)
            if (adv[k] && v_reg[k-1])
                d_reg[k] <= div_steps(d_reg[k-1]);
    end

    assign out_valid = v_reg[NST-1];
    assign out_data  = d_reg[NST-1];

endmodule

// ===== sv/alc_lux.sv =====
// coefficient lookup, products and rounded lux
module alc_lux (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  alc_pkg::div_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [20:0]     lux,
    output logic            invalid
);
    import alc_pkg::*;

    logic              va_reg, vb_reg, vc_reg;
    logic              adv_a, adv_b, adv_c;
    logic [CH_W-1:0]   a_ch0_reg, a_ch1_reg;
    coef_t             a_coef_reg;
    logic              a_bad_reg, b_bad_reg;
    logic [PROD_W-1:0] b_pos_reg, b_neg_reg;
    logic [LUX_W-1:0]  c_lux_reg;
    logic              c_bad_reg;
    logic [QUO_W-1:0]  q;
    logic [QUO_W:0]    qsum;
    coef_t             coef_next;
    logic [PROD_W-1:0] diff;
    logic [PROD_W:0]   rnd;

    assign adv_c    = !vc_reg || out_ready;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_comb
    begin
        if (in_data.zro)
            q = '0;
        else if (in_data.sat)
            q = '1;
        else
            q = in_data.quo;
        qsum      = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
        coef_next = coef_lookup(in_data.pkg, qsum[QUO_W:1]);
        // negative difference clamps to zero
        diff = (b_pos_reg > b_neg_reg) ? (b_pos_reg - b_neg_reg) : '0;
        rnd  = {1'b0, diff} + (PROD_W+1)'(1 << (SCALE_LUX - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= in_valid;
            if (adv_b)
                vb_reg <= va_reg;
            if (adv_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            a_ch0_reg  <= in_data.ch0s;
            a_ch1_reg  <= in_data.ch1s;
            a_coef_reg <= coef_next;
            a_bad_reg  <= in_data.bad;
        end
        if (adv_b && va_reg)
        begin
            b_pos_reg <= {{COEF_W{1'b0}}, a_ch0_reg} * {{CH_W{1'b0}}, a_coef_reg.b};
            b_neg_reg <= {{COEF_W{1'b0}}, a_ch1_reg} * {{CH_W{1'b0}}, a_coef_reg.m};
            b_bad_reg <= a_bad_reg;
        end
        if (adv_c && vb_reg)
        begin
            c_lux_reg <= rnd[SCALE_LUX+LUX_W-1:SCALE_LUX];
            c_bad_reg <= b_bad_reg;
        end
    end

    assign out_valid = vc_reg;
    assign lux       = c_lux_reg;
    assign invalid   = c_bad_reg;

endmodule
